>>> design/scc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// shared types and constants of the sphere clip-space culling block
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int ENT_W      = 20;  // matrix entry, signed Q10.10
  localparam int COORD_W    = 24;  // coordinate and radius, signed Q14.10
  localparam int ID_W       = 16;
  localparam int PROD_W     = ENT_W + COORD_W;      // one matrix product
  localparam int CLIP_W     = PROD_W + 2;           // clip value, 20 fraction bits
  localparam int RAD_W      = ENT_W + COORD_W - 1;  // |diag| * positive radius
  localparam int CMP_W      = CLIP_W + 2;           // widened bound compare
  localparam int ONE_SHIFT  = 10;                   // homogeneous 1 at Q10
  localparam int W_THRESHOLD = 105;                 // 0.0001 at 20 fraction bits
  localparam int CFG_DATA_W = 3 * ENT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_VP_REGS = 5;
  localparam int PIPE_DEPTH = 5;
  localparam int OCC_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VP_0,
    REG_VP_1,
    REG_VP_2,
    REG_VP_3,
    REG_VP_4,
    REG_VP_LAST,
    REG_PROJ_DIAG
  } cfg_reg_e;

  typedef struct packed {
    logic [ID_W-1:0]           object_id;
    logic                      present;
    logic                      has_bounds;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] sphere_radius;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] result_id;
    logic            visible;
  } out_item_t;

  // decoded configuration seen by the datapath
  typedef struct packed {
    logic [15:0][ENT_W-1:0] ent;       // row-major view-projection matrix
    logic [2:0][ENT_W-1:0]  diag_abs;  // |P00|, |P11|, |P22|
  } mat_cfg_t;

  // per-transaction control that rides along the pipeline
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            present;
    logic            trivial;  // no bounds or radius <= 0
  } meta_t;

  typedef struct packed {
    meta_t                  meta;
    logic [3:0][CLIP_W-1:0] clip;  // cx, cy, cz, cw
    logic [2:0][RAD_W-1:0]  rad;   // rx, ry, rz
  } clip_item_t;

endpackage

>>> design/sphere_clip_space_cull.sv
`timescale 1ns / 1ps
// five register stages from input to result; each holds one item with its own valid bit
// throughput: one transaction per cycle while the output is not stalled
// stall: a stage advances when empty or when its successor advances, so bubbles fill up
// reset: rst_ni asynchronous active low clears all valid bits and the configuration
//   registers (matrix and diagonal read as zero until written)
// ----------------------------------------------------------------------------
// sphere_clip_space_cull
// bounding-sphere visibility test of one object against the view frustum
// ----------------------------------------------------------------------------
module sphere_clip_space_cull (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [scc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [scc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // object input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  scc_pkg::in_item_t               in_item_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output scc_pkg::out_item_t              out_item_o
);

  scc_pkg::mat_cfg_t    mat_cfg;
  logic                 mid_valid;
  logic                 mid_ready;
  scc_pkg::clip_item_t  mid_item;

  // configuration registers; the user must write them only while no transaction is
  // in flight (the block does not enforce it), so the datapath reads them directly
  scc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (mat_cfg)
  );

  // stages 1..3: 15 parallel products (12 matrix 20x24, 3 radius 20x23), then a
  // two-level adder tree per clip row
  scc_transform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (mat_cfg),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item_i),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .clip_o  (mid_item)
  );

  // stages 4..5: |w| with the degenerate check, then the widened bound
  // compares; stage 5 is the output register
  scc_bound_test u_test (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (mid_valid),
    .ready_o  (mid_ready),
    .clip_i   (mid_item),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (out_item_o)
  );

  // ---------------------------------------------------------------------------
  // in-flight count, used by the checks below
  // ---------------------------------------------------------------------------
  logic [scc_pkg::OCC_W-1:0] occ_q, occ_d;
  logic                      push, pop;

  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    occ_d = occ_q;
    if (push && !pop) begin
      occ_d = occ_q + 1'b1;
    end else if (pop && !push) begin
      occ_d = occ_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // never more transactions in flight than pipeline stages
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= scc_pkg::OCC_W'(scc_pkg::PIPE_DEPTH))
    else $error("more transactions in flight than stages");

  // a result shows only for a transaction that was accepted
  a_out_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (occ_q != '0))
    else $error("result without an accepted transaction");

  // input backpressure only once every stage holds an item
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (occ_q == scc_pkg::OCC_W'(scc_pkg::PIPE_DEPTH)))
    else $error("input stalled with a free stage");

endmodule

>>> design/scc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_cfg_regs
// configuration registers and decode of the matrix and diagonal entries
// ----------------------------------------------------------------------------
module scc_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [scc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [scc_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  output scc_pkg::mat_cfg_t                    cfg_o
);

  logic [scc_pkg::NUM_VP_REGS-1:0][scc_pkg::CFG_DATA_W-1:0] vp_q;
  logic [scc_pkg::ENT_W-1:0]                                last_q;
  logic [scc_pkg::CFG_DATA_W-1:0]                           diag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q   <= '0;
      last_q <= '0;
      diag_q <= '0;
    end else if (cfg_we_i) begin
      case (scc_pkg::cfg_reg_e'(cfg_idx_i))
        scc_pkg::REG_VP_0:      vp_q[0] <= cfg_wdata_i;
        scc_pkg::REG_VP_1:      vp_q[1] <= cfg_wdata_i;
        scc_pkg::REG_VP_2:      vp_q[2] <= cfg_wdata_i;
        scc_pkg::REG_VP_3:      vp_q[3] <= cfg_wdata_i;
        scc_pkg::REG_VP_4:      vp_q[4] <= cfg_wdata_i;
        scc_pkg::REG_VP_LAST:   last_q  <= cfg_wdata_i[scc_pkg::ENT_W-1:0];
        scc_pkg::REG_PROJ_DIAG: diag_q  <= cfg_wdata_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_comb begin
    logic [scc_pkg::ENT_W-1:0] d;
    for (int k = 0; k < scc_pkg::NUM_VP_REGS; k++) begin
      for (int s = 0; s < 3; s++) begin
        cfg_o.ent[3*k+s] = vp_q[k][scc_pkg::ENT_W*s +: scc_pkg::ENT_W];
      end
    end
    cfg_o.ent[15] = last_q;
    for (int s = 0; s < 3; s++) begin
      d = diag_q[scc_pkg::ENT_W*s +: scc_pkg::ENT_W];
      cfg_o.diag_abs[s] = d[scc_pkg::ENT_W-1] ? (~d + 1'b1) : d;
    end
  end

endmodule

>>> design/scc_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_transform
// three-stage clip transform: products, pair sums, row sums
// ----------------------------------------------------------------------------
module scc_transform (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  scc_pkg::mat_cfg_t       cfg_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  scc_pkg::in_item_t       item_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output scc_pkg::clip_item_t     clip_o
);

  localparam int PW = scc_pkg::PROD_W;
  localparam int CW = scc_pkg::CLIP_W;
  localparam int EW = scc_pkg::ENT_W;

  // stage 1: products
  logic                                  v1_q;
  logic [3:0][2:0][PW-1:0]               prod_q, prod_d;
  logic [3:0][CW-1:0]                    wterm_q, wterm_d;
  logic [2:0][scc_pkg::RAD_W-1:0]        rad1_q, rad1_d;
  scc_pkg::meta_t                        meta1_q, meta1_d;
  // stage 2: pair sums
  logic                                  v2_q;
  logic [3:0][1:0][CW-1:0]               pair_q, pair_d;
  logic [2:0][scc_pkg::RAD_W-1:0]        rad2_q;
  scc_pkg::meta_t                        meta2_q;
  // stage 3: row sums
  logic                                  v3_q;
  logic [3:0][CW-1:0]                    clip_q, clip_d;
  logic [2:0][scc_pkg::RAD_W-1:0]        rad3_q;
  scc_pkg::meta_t                        meta3_q;

  logic rdy1, rdy2, rdy3;
  logic [2:0][scc_pkg::COORD_W-1:0] coord;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  assign coord = {item_i.origin_z, item_i.origin_y, item_i.origin_x};

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = $signed(cfg_i.ent[4*r+c]) * $signed(coord[c]);
      end
      // w column times the homogeneous 1
      wterm_d[r] = {{(CW-EW-scc_pkg::ONE_SHIFT){cfg_i.ent[4*r+3][EW-1]}},
                    cfg_i.ent[4*r+3], {scc_pkg::ONE_SHIFT{1'b0}}};
    end
    for (int c = 0; c < 3; c++) begin
      rad1_d[c] = cfg_i.diag_abs[c] * item_i.sphere_radius[scc_pkg::COORD_W-2:0];
    end
    meta1_d.id      = item_i.object_id;
    meta1_d.present = item_i.present;
    meta1_d.trivial = !item_i.has_bounds || item_i.sphere_radius[scc_pkg::COORD_W-1]
                      || (item_i.sphere_radius == '0);
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      pair_d[r][0] = {{(CW-PW){prod_q[r][0][PW-1]}}, prod_q[r][0]}
                   + {{(CW-PW){prod_q[r][1][PW-1]}}, prod_q[r][1]};
      pair_d[r][1] = {{(CW-PW){prod_q[r][2][PW-1]}}, prod_q[r][2]} + wterm_q[r];
      clip_d[r]    = pair_q[r][0] + pair_q[r][1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      prod_q  <= prod_d;
      wterm_q <= wterm_d;
      rad1_q  <= rad1_d;
      meta1_q <= meta1_d;
    end
    if (rdy2 && v1_q) begin
      pair_q  <= pair_d;
      rad2_q  <= rad1_q;
      meta2_q <= meta1_q;
    end
    if (rdy3 && v2_q) begin
      clip_q  <= clip_d;
      rad3_q  <= rad2_q;
      meta3_q <= meta2_q;
    end
  end

  assign valid_o     = v3_q;
  assign clip_o.meta = meta3_q;
  assign clip_o.clip = clip_q;
  assign clip_o.rad  = rad3_q;

endmodule

>>> design/scc_bound_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_bound_test
// two-stage frustum test: |w| and degenerate check, then widened bound compare
// ----------------------------------------------------------------------------
module scc_bound_test (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  scc_pkg::clip_item_t     clip_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output scc_pkg::out_item_t      result_o
);

  localparam int CW = scc_pkg::CLIP_W;
  localparam int MW = scc_pkg::CMP_W;

  // stage 4
  logic                            v4_q;
  logic [CW-1:0]                   cw_abs_q, cw_abs_d;
  logic                            degen_q, degen_d;
  logic [2:0][CW-1:0]              xyz_q;
  logic [2:0][scc_pkg::RAD_W-1:0]  rad_q;
  scc_pkg::meta_t                  meta_q;
  // stage 5, output register
  logic                            v5_q;
  scc_pkg::out_item_t              res_q, res_d;

  logic rdy4, rdy5;

  assign rdy5    = !v5_q || ready_i;
  assign rdy4    = !v4_q || rdy5;
  assign ready_o = rdy4;

  always_comb begin
    logic [CW-1:0] cw;
    cw       = clip_i.clip[3];
    cw_abs_d = cw[CW-1] ? (~cw + 1'b1) : cw;
    degen_d  = cw_abs_d <= CW'(scc_pkg::W_THRESHOLD);
  end

  always_comb begin
    logic signed [MW-1:0] lim [3];
    logic signed [MW-1:0] crd [3];
    logic signed [MW-1:0] rz;
    logic                 in_frustum;
    for (int a = 0; a < 3; a++) begin
      lim[a] = MW'(cw_abs_q) + MW'(rad_q[a]);
      crd[a] = MW'($signed(xyz_q[a]));
    end
    rz         = MW'(rad_q[2]);
    in_frustum = (crd[0] >= -lim[0]) && (crd[0] <= lim[0])
              && (crd[1] >= -lim[1]) && (crd[1] <= lim[1])
              && (crd[2] >= -rz)     && (crd[2] <= lim[2]);
    res_d.result_id = meta_q.id;
    res_d.visible   = meta_q.present && (meta_q.trivial || (!degen_q && in_frustum));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy4) begin
        v4_q <= valid_i;
      end
      if (rdy5) begin
        v5_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && valid_i) begin
      cw_abs_q <= cw_abs_d;
      degen_q  <= degen_d;
      xyz_q    <= clip_i.clip[2:0];
      rad_q    <= clip_i.rad;
      meta_q   <= clip_i.meta;
    end
    if (rdy5 && v4_q) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = v5_q;
  assign result_o = res_q;

endmodule
